### hw/rtl/segsum_pkg.sv
// Package for the segment tree range sum unit.
// Holds the tree size, field and node widths, operation codes and the sequencer states.
// No dependencies.
`default_nettype none

package segsum_pkg;

  // Tree size and field widths
  localparam int LEAF_COUNT = 1024;
  localparam int LEAF_IDX_W = 10;
  localparam int VALUE_W    = 16;
  localparam int OUT_W      = 26;

  // Node sums grow by one bit per tree level, plus a sign bit of headroom
  localparam int NODE_W  = VALUE_W + $clog2(LEAF_COUNT) + 1;
  localparam int NODE_AW = $clog2(2 * LEAF_COUNT);
  localparam int NODE_DEPTH = 2 * LEAF_COUNT;

  // Width for index compares and the query bounds, which can reach 2*LEAF_COUNT
  localparam int CMP_W = ((LEAF_IDX_W > NODE_AW) ? LEAF_IDX_W : NODE_AW) + 1;

  // Accumulator is always wider than the result, so saturation is a simple check
  localparam int ACC_W = (NODE_W > OUT_W) ? NODE_W : OUT_W + 1;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLIMB,
    ST_Q_LO,
    ST_Q_HI,
    ST_Q_SUM
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/segsum_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module segsum_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/segment_tree_range_sum_unit.sv
// Top level of the segment tree range sum unit: sequencer, node memory and result register.
// Depends on segsum_pkg and segsum_ram.
//
// The unit keeps a bottom-up sum tree over LEAF_COUNT signed 16-bit leaves in one node memory
// with a single write and a single read port. After reset it runs a clearing pass over all
// 2*LEAF_COUNT nodes (2048) that zeroes every node; in_ready stays low until it is done.
// An update transaction writes the leaf and then climbs one tree level per cycle up to the
// root; an update with a leaf index beyond the tree is dropped in the cycle it is accepted.
// A query transaction walks the range bounds up the tree, visiting ST_Q_LO and ST_Q_HI at
// each level with at most one node read in each, then ends in ST_Q_SUM; an empty or
// reversed range skips the walk. The single read port of the node memory sets this pace.
// The result waits in an output register, so updates proceed while a query result has
// not been taken; a following query holds in its last cycle until the register is free.
`default_nettype none

module segment_tree_range_sum_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  operation,
  input  wire logic        [segsum_pkg::LEAF_IDX_W-1:0] leaf_index,
  input  wire logic signed [segsum_pkg::VALUE_W-1:0]    leaf_value,
  input  wire logic        [segsum_pkg::LEAF_IDX_W-1:0] range_first,
  input  wire logic        [segsum_pkg::LEAF_IDX_W-1:0] range_last,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed      [segsum_pkg::OUT_W-1:0]      range_total
);

  import segsum_pkg::*;

  localparam logic [CMP_W-1:0] LEAVES = CMP_W'(LEAF_COUNT);

  state_t state, state_next;

  logic [NODE_AW-1:0]      clr_cnt, clr_cnt_next;
  logic [NODE_AW-1:0]      pos, pos_next;
  logic signed [NODE_W-1:0] cur, cur_next;
  logic [CMP_W-1:0]        lo, lo_next;
  logic [CMP_W-1:0]        hi, hi_next;
  logic signed [ACC_W-1:0] acc;
  logic                    acc_clear;
  logic                    rd_pend;
  logic                    out_load;

  // Node memory ports
  logic                     ram_we;
  logic [NODE_AW-1:0]       ram_waddr;
  logic [NODE_W-1:0]        ram_wdata;
  logic                     ram_re;
  logic [NODE_AW-1:0]       ram_raddr;
  logic [NODE_W-1:0]        ram_rdata;
  logic signed [NODE_W-1:0] node_rd;

  // Decoded input fields
  logic                     in_fire;
  logic [CMP_W-1:0]         idx_x, first_x, last_x, last_c, leaf_pos;
  logic                     range_empty;
  logic signed [NODE_W-1:0] climb_sum;
  logic [NODE_AW-1:0]       parent;
  logic [ACC_W-OUT_W:0]     acc_top;
  logic signed [OUT_W-1:0]  total_sat;

  segsum_ram #(
    .WIDTH(NODE_W),
    .DEPTH(NODE_DEPTH)
  ) u_nodes (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign node_rd  = signed'(ram_rdata);
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Extend indices and clip the query end to the last leaf
  assign idx_x       = CMP_W'(leaf_index);
  assign first_x     = CMP_W'(range_first);
  assign last_x      = CMP_W'(range_last);
  assign last_c      = (last_x >= LEAVES) ? (LEAVES - CMP_W'(1)) : last_x;
  assign range_empty = (first_x >= LEAVES) || (first_x > last_c);
  assign leaf_pos    = idx_x + LEAVES;

  // One level of the update climb
  assign climb_sum = NODE_W'(cur + node_rd);
  assign parent    = pos >> 1;

  // Saturate the accumulator to the result width
  assign acc_top   = acc[ACC_W-1:OUT_W-1];
  assign total_sat = ((&acc_top) || !(|acc_top)) ? acc[OUT_W-1:0]
                   : (acc[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}});

  // Sequencer: next state, memory accesses and bound updates
  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    pos_next     = pos;
    cur_next     = cur;
    lo_next      = lo;
    hi_next      = hi;
    acc_clear    = 1'b0;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = pos;
    ram_wdata    = cur;
    ram_re       = 1'b0;
    ram_raddr    = pos;
    case (state)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_cnt;
        ram_wdata    = '0;
        clr_cnt_next = clr_cnt + NODE_AW'(1);
        if (&clr_cnt) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (operation == OP_UPDATE) begin
            // Write the leaf and fetch its sibling; drop indices beyond the tree
            if (idx_x < LEAVES) begin
              ram_we     = 1'b1;
              ram_waddr  = leaf_pos[NODE_AW-1:0];
              ram_wdata  = NODE_W'(leaf_value);
              ram_re     = 1'b1;
              ram_raddr  = leaf_pos[NODE_AW-1:0] ^ NODE_AW'(1);
              pos_next   = leaf_pos[NODE_AW-1:0];
              cur_next   = NODE_W'(leaf_value);
              state_next = ST_CLIMB;
            end
          end else begin
            acc_clear = 1'b1;
            if (range_empty) begin
              lo_next = '0;
              hi_next = '0;
            end else begin
              lo_next = first_x + LEAVES;
              hi_next = last_c + LEAVES + CMP_W'(1);
            end
            state_next = ST_Q_LO;
          end
        end
      end
      ST_CLIMB: begin
        // Sibling data is here: write the parent and fetch the parent's sibling
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = climb_sum;
        cur_next  = climb_sum;
        pos_next  = parent;
        if (parent > NODE_AW'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = parent ^ NODE_AW'(1);
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_Q_LO: begin
        if (lo < hi) begin
          if (lo[0]) begin
            ram_re    = 1'b1;
            ram_raddr = lo[NODE_AW-1:0];
            lo_next   = lo + CMP_W'(1);
          end
          state_next = ST_Q_HI;
        end else begin
          state_next = ST_Q_SUM;
        end
      end
      ST_Q_HI: begin
        if (hi[0]) begin
          ram_re    = 1'b1;
          ram_raddr = hi[NODE_AW-1:0] - NODE_AW'(1);
        end
        // Move both bounds up one level
        lo_next    = lo >> 1;
        hi_next    = (hi - CMP_W'(hi[0])) >> 1;
        state_next = ST_Q_LO;
      end
      ST_Q_SUM: begin
        // Hold until the result register is free
        out_load = !out_valid || out_ready;
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      rd_pend <= ram_re;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pos <= pos_next;
    cur <= cur_next;
    lo  <= lo_next;
    hi  <= hi_next;
    if (acc_clear) begin
      acc <= '0;
    end else if (rd_pend) begin
      acc <= ACC_W'(acc + ACC_W'(node_rd));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      range_total <= total_sat;
    end
  end

  // Every node read of a query lands before the total is taken
  a_no_read_at_sum: assert property (@(posedge clk) disable iff (rst)
    state == ST_Q_SUM |-> !rd_pend)
    else $error("node read still in flight when the range total is taken");

  // Query bounds never cross while walking the tree
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_LO || state == ST_Q_HI) |-> lo <= hi)
    else $error("query bounds crossed");

  // A result appears only from the final query cycle
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_Q_SUM)
    else $error("result valid without a finished query");

  // An in-range update starts its climb in the next cycle
  a_update_climbs: assert property (@(posedge clk) disable iff (rst)
    in_fire && operation == OP_UPDATE && idx_x < LEAVES |=> state == ST_CLIMB)
    else $error("accepted update did not start its climb");

  // The climb writes every level up to the root, which is the last one written
  a_climb_ends_at_root: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLIMB && state_next == ST_IDLE |-> parent == NODE_AW'(1))
    else $error("update climb ended below the root");

endmodule

`default_nettype wire
